// File: sv/sfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the sensor frame checker.
`default_nettype none
package sfc_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  HEAD_FIRST  = 8'hAA;
  localparam logic [7:0]  HEAD_SECOND = 8'hBB;
  localparam logic [7:0]  TAIL_FIRST  = 8'hCC;
  localparam logic [7:0]  TAIL_SECOND = 8'hDD;
  localparam int          MIN_FRAME   = 11;
  localparam int          POS_W       = 4;
  localparam logic [POS_W-1:0] POS_MAX   = 4'd15;
  localparam logic [POS_W-1:0] POS_SHORT = 4'(MIN_FRAME - 1);

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_HEADER = 3'd2,
    ST_TAIL   = 3'd3,
    ST_CRC    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } sfc_in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] unit_id;
    logic [7:0]  sensor_type;
    logic [15:0] declared_length;
    logic [15:0] computed_crc;
  } sfc_out_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/sfc_frame_state.sv
// Frame state: position, header check, field capture, delay window, CRC and verdict.
`default_nettype none
module sfc_frame_state
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire sfc_in_t  item_i,
  output sfc_out_t      res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       win_q [4];
  logic [7:0]       win_d [4];
  logic             hdr_q, hdr_d;
  logic [31:0]      id_q, id_d;
  logic [7:0]       type_q, type_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      crc_fin;
  logic [15:0]      crc_expect;
  logic             full;

  assign crc_fin    = crc_feed(crc_q, win_q[0]);
  assign crc_expect = {win_q[1], win_q[2]};

  always_comb begin
    full = 1'b0;
    res_o.status = ST_OK;
    if (pos_q < POS_SHORT) begin
      res_o.status = ST_SHORT;
    end else if (!hdr_q) begin
      res_o.status = ST_HEADER;
    end else if (win_q[3] != TAIL_FIRST || item_i.data_byte != TAIL_SECOND) begin
      res_o.status = ST_TAIL;
    end else begin
      full = 1'b1;
      res_o.status = (crc_fin == crc_expect) ? ST_OK : ST_CRC;
    end
    res_o.unit_id         = full ? id_q : 32'h0;
    res_o.sensor_type     = full ? type_q : 8'h00;
    res_o.declared_length = full ? len_q : 16'h0000;
    res_o.computed_crc    = full ? crc_fin : 16'h0000;
  end

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    win_d  = win_q;
    hdr_d  = hdr_q;
    id_d   = id_q;
    type_d = type_q;
    len_d  = len_q;
    if (item_i.frame_end) begin
      pos_d  = '0;
      crc_d  = CRC_INIT;
      win_d  = '{default: 8'h00};
      hdr_d  = 1'b0;
      id_d   = '0;
      type_d = '0;
      len_d  = '0;
    end else begin
      if (pos_q == 4'd0) begin
        hdr_d = (item_i.data_byte == HEAD_FIRST);
      end else if (pos_q == 4'd1) begin
        hdr_d = hdr_q && (item_i.data_byte == HEAD_SECOND);
      end
      if (pos_q >= 4'd2 && pos_q <= 4'd5) begin
        id_d = {id_q[23:0], item_i.data_byte};
      end else if (pos_q == 4'd6) begin
        type_d = item_i.data_byte;
      end else if (pos_q == 4'd7 || pos_q == 4'd8) begin
        len_d = {len_q[7:0], item_i.data_byte};
      end
      if (pos_q >= 4'd2) begin
        if (pos_q >= 4'd6) begin
          crc_d = crc_fin;
        end
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = win_q[3];
        win_d[3] = item_i.data_byte;
      end
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CRC_INIT;
      win_q  <= '{default: 8'h00};
      hdr_q  <= 1'b0;
      id_q   <= '0;
      type_q <= '0;
      len_q  <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      win_q  <= win_d;
      hdr_q  <= hdr_d;
      id_q   <= id_d;
      type_q <= type_d;
      len_q  <= len_d;
    end
  end

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.frame_end |=> pos_q == '0 && crc_q == CRC_INIT && !hdr_q)
    else $error("frame state not cleared after last byte");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.frame_end && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 4'd1)
    else $error("byte position did not advance");

  a_crc_hold_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.frame_end && pos_q < 4'd6 |=> crc_q == CRC_INIT)
    else $error("CRC moved before the window filled");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.status == ST_SHORT || res_o.status == ST_HEADER || res_o.status == ST_TAIL)
      |-> res_o.unit_id == '0 && res_o.computed_crc == '0)
    else $error("fields not cleared on a failed frame");

endmodule
`default_nettype wire

// File: sv/sfc_result_reg.sv
// Output register holding one verdict until the receiver takes it.
`default_nettype none
module sfc_result_reg
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire sfc_out_t res_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sfc_out_t      out_data_o
);

  logic     vld_q, vld_d;
  sfc_out_t res_q;

  assign ready_o     = !vld_q || !out_stall_i;
  assign out_valid_o = vld_q;
  assign out_data_o  = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/sensor_frame_checker_core.sv
// Top level of the sensor frame checker: input register, frame state and result register.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one frame byte per
//   request, with frame_end set on the last byte of a frame.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one verdict per
//   frame: status, unit id, sensor type, declared length and computed CRC.
//   Throughput is one byte per cycle unless stalled; the CRC byte update is unrolled.
//   A byte is held in the input register; its verdict, if it ends a frame,
//   is registered again in the result register before it is shown on the output.
//   Bytes that do not end a frame never wait on the output side.
//   When the receiver stalls with a verdict pending, a last byte waits in the
//   input register and the input stalls only while that byte cannot advance.
//   Reset clears the frame state, so the first byte after reset starts a frame,
//   and empties both registers. Every verdict also clears the frame state.
`default_nettype none
module sensor_frame_checker_core
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire sfc_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sfc_out_t      out_data_o
);

  logic     in_vld_q, in_vld_d;
  sfc_in_t  in_q;
  logic     accept;
  logic     adv;
  logic     out_ready;
  sfc_out_t res;

  assign adv        = in_vld_q && (!in_q.frame_end || out_ready);
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  sfc_frame_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  sfc_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && in_q.frame_end),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
